// File: src/harmonic_trig_recurrence_macros.svh
// Assertion macros used by the harmonic generator controller.
`ifndef HARMONIC_TRIG_RECURRENCE_MACROS_SVH
`define HARMONIC_TRIG_RECURRENCE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HTR_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("harmonic generator: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define HTR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("harmonic generator: next-cycle check failed");

`endif

// File: src/htr_pkg.sv
`timescale 1ns / 1ps

package htr_pkg;

  // Data format: signed fixed point with two integer bits.
  localparam int DW = 32;
  localparam int FRAC_W = DW - 2;
  localparam int PROD_W = 2 * DW;
  localparam int ACC_W = PROD_W + 1;

  // Harmonic count range and index width.
  localparam int MAX_HARMONICS = 64;
  localparam int IDX_W = $clog2(MAX_HARMONICS);
  localparam int CNT_W = 7;
  localparam logic [CNT_W-1:0] COUNT_RESET = 7'd64;

  localparam logic signed [DW-1:0] FIX_ONE = {2'b01, {FRAC_W{1'b0}}};
  localparam logic signed [DW-1:0] FIX_ZERO = '0;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    {{(ACC_W - FRAC_W){1'b0}}, 1'b1, {(FRAC_W - 1){1'b0}}};

  // Accumulator operation for one datapath step.
  typedef enum logic [1:0] {
    ACC_HOLD = 2'd0,
    ACC_INIT = 2'd1,
    ACC_SUB  = 2'd2,
    ACC_ADD  = 2'd3
  } acc_op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    load_in;
    logic    emit;
    logic    step_k;
    logic    load_base;
    logic    mul_en;
    logic    a_is_ps;
    logic    b_is_bs;
    acc_op_t acc_op;
    logic    wr_pc;
    logic    wr_ps;
  } htr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
    logic is_last;
    logic k_is_zero;
  } htr_sts_t;

  // Shift out the fraction bits of a rounded sum and saturate to DW bits.
  function automatic logic signed [DW-1:0] shift_sat(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] sh;
    logic signed [DW-1:0] res;
    sh = v >>> FRAC_W;
    if (sh[ACC_W-1:DW-1] == {(ACC_W - DW + 1){sh[ACC_W-1]}}) begin
      res = sh[DW-1:0];
    end else if (sh[ACC_W-1]) begin
      res = {1'b1, {(DW - 1){1'b0}}};
    end else begin
      res = {1'b0, {(DW - 1){1'b1}}};
    end
    return res;
  endfunction

endpackage

// File: src/htr_datapath.sv
`timescale 1ns / 1ps

module htr_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  htr_pkg::htr_cmd_t              cmd,
  output htr_pkg::htr_sts_t              sts,
  input  logic                           cfg_valid,
  input  logic [htr_pkg::CNT_W-1:0]      harmonic_count,
  input  logic signed [htr_pkg::DW-1:0]  base_cos,
  input  logic signed [htr_pkg::DW-1:0]  base_sin,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [htr_pkg::DW-1:0]  cos_multiple,
  output logic signed [htr_pkg::DW-1:0]  sin_multiple,
  output logic [htr_pkg::IDX_W-1:0]      harmonic_index,
  output logic                           last_pair
);
  import htr_pkg::*;

  logic [CNT_W-1:0] count_reg;
  logic [IDX_W-1:0] last_idx;
  logic [IDX_W-1:0] last_idx_next;
  logic [IDX_W-1:0] k;
  logic signed [DW-1:0] bc;
  logic signed [DW-1:0] bs;
  logic signed [DW-1:0] pc;
  logic signed [DW-1:0] ps;
  logic signed [DW-1:0] mul_a;
  logic signed [DW-1:0] mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0] prod_ext;
  logic signed [ACC_W-1:0] acc;

  // Configuration register; the port is always ready.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_reg <= COUNT_RESET;
    end else if (cfg_valid) begin
      count_reg <= harmonic_count;
    end
  end

  // Clamp the count to one through the maximum and keep the final index.
  always_comb begin
    if (count_reg == '0) begin
      last_idx_next = '0;
    end else if (count_reg > CNT_W'(MAX_HARMONICS)) begin
      last_idx_next = IDX_W'(MAX_HARMONICS - 1);
    end else begin
      last_idx_next = IDX_W'(count_reg - CNT_W'(1));
    end
  end

  // Base angle, running pair and harmonic counter.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      bc       <= base_cos;
      bs       <= base_sin;
      pc       <= FIX_ONE;
      ps       <= FIX_ZERO;
      k        <= '0;
      last_idx <= last_idx_next;
    end else begin
      if (cmd.step_k) begin
        k <= k + IDX_W'(1);
      end
      if (cmd.load_base) begin
        pc <= bc;
        ps <= bs;
      end
      if (cmd.wr_pc) begin
        pc <= shift_sat(acc);
      end
      if (cmd.wr_ps) begin
        ps <= shift_sat(acc);
      end
    end
  end

  // Shared multiplier with a registered product.
  assign mul_a = cmd.a_is_ps ? ps : pc;
  assign mul_b = cmd.b_is_bs ? bs : bc;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      prod <= mul_a * mul_b;
    end
  end

  // Accumulator for the exact sum of two products plus the rounding half.
  assign prod_ext = {prod[PROD_W-1], prod};

  always_ff @(posedge clk) begin
    case (cmd.acc_op)
      ACC_INIT: acc <= prod_ext + ROUND_HALF;
      ACC_SUB:  acc <= acc - prod_ext;
      ACC_ADD:  acc <= acc + prod_ext;
      default:  acc <= acc;
    endcase
  end

  // Output register; a pair waits here until its transfer completes.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      cos_multiple   <= pc;
      sin_multiple   <= ps;
      harmonic_index <= k;
      last_pair      <= (k == last_idx);
    end
  end

  // Status for the controller.
  assign sts.out_free  = !out_valid || out_ready;
  assign sts.is_last   = (k == last_idx);
  assign sts.k_is_zero = (k == '0);

endmodule

// File: src/htr_controller.sv
`timescale 1ns / 1ps
`include "harmonic_trig_recurrence_macros.svh"

module htr_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  htr_pkg::htr_sts_t sts,
  output htr_pkg::htr_cmd_t cmd
);
  import htr_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_EMIT = 7'b0000010,
    S_P0   = 7'b0000100,
    S_P1   = 7'b0001000,
    S_P2   = 7'b0010000,
    S_P3   = 7'b0100000,
    S_P4   = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;
  logic   wr_ps_step;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Sequencing: emit a pair, then six multiply and accumulate steps per
  // later pair. The last step is folded into the emit state entry below.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ps_step <= 1'b0;
    end else begin
      wr_ps_step <= (state == S_P4);
    end
  end

  always_comb begin
    state_next  = state;
    in_ready    = 1'b0;
    cmd         = '0;
    cmd.acc_op  = ACC_HOLD;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_EMIT;
        end
      end
      S_EMIT: begin
        // The sine update of the previous step lands before any emit.
        cmd.wr_ps = wr_ps_step;
        if (sts.out_free && !wr_ps_step) begin
          cmd.emit = 1'b1;
          if (sts.is_last) begin
            state_next = S_IDLE;
          end else begin
            cmd.step_k = 1'b1;
            if (sts.k_is_zero) begin
              cmd.load_base = 1'b1;
            end else begin
              state_next = S_P0;
            end
          end
        end
      end
      S_P0: begin
        cmd.mul_en = 1'b1;
        state_next = S_P1;
      end
      S_P1: begin
        cmd.acc_op  = ACC_INIT;
        cmd.mul_en  = 1'b1;
        cmd.a_is_ps = 1'b1;
        cmd.b_is_bs = 1'b1;
        state_next  = S_P2;
      end
      S_P2: begin
        cmd.acc_op  = ACC_SUB;
        cmd.mul_en  = 1'b1;
        cmd.b_is_bs = 1'b1;
        state_next  = S_P3;
      end
      S_P3: begin
        cmd.wr_pc   = 1'b1;
        cmd.acc_op  = ACC_INIT;
        cmd.mul_en  = 1'b1;
        cmd.a_is_ps = 1'b1;
        state_next  = S_P4;
      end
      S_P4: begin
        cmd.acc_op = ACC_ADD;
        state_next = S_EMIT;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Checks on the sequencing.
  `HTR_ASSERT_IMPL(a_emit_needs_room, clk, rst, cmd.emit, sts.out_free)
  `HTR_ASSERT_IMPL(a_no_product_before_base, clk, rst, state == S_P0, !sts.k_is_zero)
  `HTR_ASSERT_NEXT(a_accept_goes_emit, clk, rst, in_valid && in_ready, state == S_EMIT)
  `HTR_ASSERT_NEXT(a_last_goes_idle, clk, rst, cmd.emit && sts.is_last, state == S_IDLE)
  `HTR_ASSERT_IMPL(a_ps_write_not_with_emit, clk, rst, cmd.wr_ps, !cmd.emit)

endmodule

// File: src/harmonic_trig_recurrence.sv
`timescale 1ns / 1ps
// Harmonic cosine/sine generator by repeated complex rotation.
// Input channel (in_valid/in_ready): one base angle as base_cos and base_sin,
// signed with two integer bits. An input transfer starts one burst of
// harmonic_count pairs (cos k*a, sin k*a), k = 0 upward, on the output channel
// (out_valid/out_ready) with harmonic_index = k and last_pair on the final one.
// Configuration channel (cfg_valid/cfg_ready, always ready): harmonic_count,
// clamped to 1..64; write it only while no burst is in progress.
// After the input transfer, the first pair passes the emit state and then
// the output register. Pairs 0 and 1 need no products; every later pair is
// formed from four products on one shared 32x32 multiplier, two accumulated
// sums and the emit, and its products start only after the previous emit.
// One angle is in work at a time; in_ready rises once the last pair of the
// burst is in the output register, so the next angle can be taken while that
// pair still waits for its transfer.
// When the receiver stalls, the pair holds in the output register and the
// sequencer waits before emitting the next one; nothing is dropped.
// Reset (rst, synchronous) empties the output register, returns to idle and
// sets harmonic_count to 64.
module harmonic_trig_recurrence (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [htr_pkg::CNT_W-1:0]     harmonic_count,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic signed [htr_pkg::DW-1:0] base_cos,
  input  logic signed [htr_pkg::DW-1:0] base_sin,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [htr_pkg::DW-1:0] cos_multiple,
  output logic signed [htr_pkg::DW-1:0] sin_multiple,
  output logic [htr_pkg::IDX_W-1:0]     harmonic_index,
  output logic                          last_pair
);
  import htr_pkg::*;

  htr_cmd_t cmd;
  htr_sts_t sts;

  // The count register takes a write in any cycle.
  assign cfg_ready = 1'b1;

  htr_controller u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  htr_datapath u_dp (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_valid      (cfg_valid),
    .harmonic_count (harmonic_count),
    .base_cos       (base_cos),
    .base_sin       (base_sin),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .cos_multiple   (cos_multiple),
    .sin_multiple   (sin_multiple),
    .harmonic_index (harmonic_index),
    .last_pair      (last_pair)
  );

endmodule
